[rtl/acpm_pkg.sv]
// acpm_pkg: shared types, constants and command/status structs for the ac power rms meter
// no dependencies
package acpm_pkg;

  localparam int unsigned CountBits = 24;
  localparam int unsigned AdcBits   = 12;

  typedef enum logic [1:0] {
    MODE_SEED   = 2'd0,
    MODE_SAMPLE = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_GAIN_U  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_HP_BETA = 3'd2,
    REG_FLOOR_U = 3'd3,
    REG_FLOOR_I = 3'd4,
    REG_FLOOR_P = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_FILT_MUL,
    ST_FILT_SUM,
    ST_ACC_MUL,
    ST_ACC_ADD,
    ST_DIV,
    ST_SQRT,
    ST_RESULT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scale;
    logic seed;
    logic filt_mul;
    logic filt_sum;
    logic acc_mul;
    logic acc_add;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic sqrt_done;
  } status_t;

endpackage

[rtl/acpm_datapath.sv]
// acpm_datapath: scaling, high-pass filters, accumulators, serial divider and square root
// depends on acpm_pkg
module acpm_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acpm_pkg::cmd_t      cmd_i,
  output acpm_pkg::status_t   status_o,
  input  logic [11:0]         raw_u_i,
  input  logic [11:0]         raw_i_i,
  input  logic [23:0]         gain_u_i,
  input  logic [23:0]         gain_i_i,
  input  logic [15:0]         hp_beta_i,
  input  logic [31:0]         floor_u_i,
  input  logic [31:0]         floor_i_i,
  input  logic [47:0]         floor_p_i,
  output logic [31:0]         rms_u_o,
  output logic [31:0]         rms_i_o,
  output logic [47:0]         mean_p_o,
  output logic [23:0]         samples_used_o
);

  localparam int unsigned CB = acpm_pkg::CountBits;
  localparam int unsigned AB = acpm_pkg::AdcBits;

  logic [AB-1:0]        raw_u_q, raw_i_q;
  logic signed [31:0]   xu_q, xi_q;
  logic signed [31:0]   pin_u_q, pout_u_q, pin_i_q, pout_i_q;
  logic signed [31:0]   u_q, i_q;
  logic signed [51:0]   ma_u_q, mb_u_q, ma_i_q, mb_i_q;
  logic [63:0]          sq_u_q, sq_i_q;
  logic signed [63:0]   pr_q;
  logic [63:0]          ssu_q, ssi_q;
  logic signed [63:0]   sp_q;
  logic [CB-1:0]        cnt_q;

  logic [1:0]           dsel_q;
  logic [63:0]          dquo_q;
  logic [CB-1:0]        drem_q;
  logic [6:0]           dcnt_q;
  logic [63:0]          msu_q, msi_q, mp_q;

  logic [1:0]           ssel_q;
  logic [63:0]          sv_q, sr_q, sbit_q;
  logic [31:0]          ru_q, ri_q;

  // scaling
  logic [AB+23:0] pu, pi;
  logic signed [31:0] xu_d, xi_d;
  always_comb begin
    pu = {24'd0, raw_u_q} * {{AB{1'b0}}, gain_u_i};
    pi = {24'd0, raw_i_q} * {{AB{1'b0}}, gain_i_i};
    xu_d = (pu > (AB+24)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(pu);
    xi_d = (pi > (AB+24)'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(pi);
  end

  // filter
  logic signed [18:0] ca, cb;
  logic signed [32:0] du, di;
  logic signed [53:0] acc_u, acc_i;
  logic signed [36:0] yu, yi;
  always_comb begin
    ca = 19'sd131072 - $signed({3'd0, hp_beta_i});
    cb = 19'sd131072 - $signed({2'd0, hp_beta_i, 1'b0});
    du = {xu_q[31], xu_q} - {pin_u_q[31], pin_u_q};
    di = {xi_q[31], xi_q} - {pin_i_q[31], pin_i_q};
    acc_u = 54'(ma_u_q) + 54'(mb_u_q) + 54'sd65536;
    acc_i = 54'(ma_i_q) + 54'(mb_i_q) + 54'sd65536;
    yu = 37'(acc_u >>> 17);
    yi = 37'(acc_i >>> 17);
  end

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -37'sh0_8000_0000) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // accumulate
  logic [31:0] mu, mi;
  logic [64:0] su, si;
  logic signed [64:0] sp;
  always_comb begin
    mu = u_q[31] ? 32'(-u_q) : 32'(u_q);
    mi = i_q[31] ? 32'(-i_q) : 32'(i_q);
    su = {1'b0, ssu_q} + {1'b0, sq_u_q};
    si = {1'b0, ssi_q} + {1'b0, sq_i_q};
    sp = {sp_q[63], sp_q} + {pr_q[63], pr_q};
  end

  logic [CB+1:0] dtry;
  logic [CB:0]   dsh;
  always_comb begin
    dsh  = {drem_q, dquo_q[63]};
    dtry = {1'b0, dsh} - {2'b0, cnt_q};
  end

  // square root step
  logic [64:0] strial;
  always_comb strial = {1'b0, sv_q} - ({1'b0, sr_q} + {1'b0, sbit_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_u_q <= '0; pout_u_q <= '0; pin_i_q <= '0; pout_i_q <= '0;
      ssu_q <= '0; ssi_q <= '0; sp_q <= '0; cnt_q <= '0;
      dsel_q <= '0; dcnt_q <= '0; ssel_q <= '0;
    end else begin
      if (cmd_i.seed) begin
        pin_u_q <= xu_q; pin_i_q <= xi_q; pout_u_q <= '0; pout_i_q <= '0;
        ssu_q <= '0; ssi_q <= '0; sp_q <= '0; cnt_q <= '0;
      end
      if (cmd_i.filt_sum) begin
        pin_u_q <= xu_q; pin_i_q <= xi_q;
        pout_u_q <= sat32(yu); pout_i_q <= sat32(yi);
      end
      if (cmd_i.acc_add) begin
        ssu_q <= su[64] ? '1 : su[63:0];
        ssi_q <= si[64] ? '1 : si[63:0];
        if (sp[64] != sp[63]) sp_q <= sp[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else sp_q <= sp[63:0];
        if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        dsel_q <= '0; dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        if (dcnt_q == 7'd64) begin
          dcnt_q <= '0;
          dsel_q <= dsel_q + 2'd1;
        end else begin
          dcnt_q <= dcnt_q + 7'd1;
        end
      end
      if (cmd_i.sqrt_start) ssel_q <= '0;
      else if (cmd_i.sqrt_step && sbit_q == '0) ssel_q <= ssel_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_u_q <= raw_u_i[AB-1:0];
      raw_i_q <= raw_i_i[AB-1:0];
    end
    if (cmd_i.scale) begin
      xu_q <= xu_d;
      xi_q <= xi_d;
    end
    if (cmd_i.filt_mul) begin
      ma_u_q <= 52'(ca) * 52'(du); mb_u_q <= 52'(cb) * 52'(pout_u_q);
      ma_i_q <= 52'(ca) * 52'(di); mb_i_q <= 52'(cb) * 52'(pout_i_q);
    end
    if (cmd_i.filt_sum) begin
      u_q <= sat32(yu);
      i_q <= sat32(yi);
    end
    if (cmd_i.acc_mul) begin
      sq_u_q <= {32'd0, mu} * {32'd0, mu};
      sq_i_q <= {32'd0, mi} * {32'd0, mi};
      pr_q   <= 64'(u_q) * 64'(i_q);
    end
    // the first dividend is the sum being written in the same cycle
    if (cmd_i.div_start || (cmd_i.div_step && dcnt_q == 7'd64)) begin
      drem_q <= '0;
      dquo_q <= cmd_i.div_start ? (su[64] ? '1 : su[63:0]) :
                (dsel_q == 2'd0 ? ssi_q : (sp_q[63] ? 64'd0 : 64'(sp_q)));
    end else if (cmd_i.div_step) begin
      if (!dtry[CB+1]) begin
        drem_q <= dtry[CB-1:0];
        dquo_q <= {dquo_q[62:0], 1'b1};
      end else begin
        drem_q <= dsh[CB-1:0];
        dquo_q <= {dquo_q[62:0], 1'b0};
      end
    end
    if (cmd_i.div_step && dcnt_q == 7'd64) begin
      unique case (dsel_q)
        2'd0:    msu_q <= dquo_q;
        2'd1:    msi_q <= dquo_q;
        default: mp_q  <= dquo_q;
      endcase
    end
    if (cmd_i.sqrt_start || (cmd_i.sqrt_step && sbit_q == '0)) begin
      sv_q   <= cmd_i.sqrt_start ? msu_q : msi_q;
      sr_q   <= '0;
      sbit_q <= 64'h4000_0000_0000_0000;
      if (cmd_i.sqrt_step && ssel_q == 2'd0) ru_q <= sr_q[31:0];
      if (cmd_i.sqrt_step && ssel_q == 2'd1) ri_q <= sr_q[31:0];
    end else if (cmd_i.sqrt_step) begin
      if (!strial[64]) begin
        sv_q <= strial[63:0];
        sr_q <= (sr_q >> 1) + sbit_q;
      end else begin
        sr_q <= sr_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.out_load) begin
      rms_u_o <= (ru_q < floor_u_i) ? '0 : ru_q;
      rms_i_o <= (ri_q < floor_i_i) ? '0 : ri_q;
      mean_p_o <= (mp_q[63:16] < floor_p_i) ? '0 : mp_q[63:16];
      samples_used_o <= 24'(cnt_q);
    end
  end

  assign status_o.div_done  = cmd_i.div_step && dcnt_q == 7'd64 && dsel_q == 2'd2;
  assign status_o.sqrt_done = cmd_i.sqrt_step && sbit_q == '0 && ssel_q == 2'd1;

  unused_div_rem_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> dcnt_q == 7'd0) else $error("divider not restarted");
  sqrt_bit_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sbit_q) || !cmd_i.sqrt_step) else $error("sqrt bit not one-hot");
  count_sat_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.acc_add && cnt_q == '1) |=> cnt_q == '1) else $error("count wrapped");

endmodule

[rtl/acpm_ctrl.sv]
// acpm_ctrl: sequencer for one item, from transfer in to transfer out
// depends on acpm_pkg
module acpm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output acpm_pkg::cmd_t    cmd_o,
  input  acpm_pkg::status_t status_i
);

  acpm_pkg::state_e state_q, state_d;
  logic [1:0] mode_q;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acpm_pkg::ST_IDLE;
      mode_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == acpm_pkg::ST_IDLE && in_valid_i) mode_q <= mode_i;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o = 1'b1;
    unique case (state_q)
      acpm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i && mode_i != acpm_pkg::MODE_NONE) begin
          cmd_o.load = 1'b1;
          state_d = acpm_pkg::ST_SCALE;
        end
      end
      acpm_pkg::ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d = (mode_q == acpm_pkg::MODE_SEED) ? acpm_pkg::ST_IDLE
                                                  : acpm_pkg::ST_FILT_MUL;
        if (mode_q == acpm_pkg::MODE_SEED) state_d = acpm_pkg::ST_RESULT;
      end
      acpm_pkg::ST_FILT_MUL: begin
        cmd_o.filt_mul = 1'b1;
        state_d = acpm_pkg::ST_FILT_SUM;
      end
      acpm_pkg::ST_FILT_SUM: begin
        cmd_o.filt_sum = 1'b1;
        state_d = acpm_pkg::ST_ACC_MUL;
      end
      acpm_pkg::ST_ACC_MUL: begin
        cmd_o.acc_mul = 1'b1;
        state_d = acpm_pkg::ST_ACC_ADD;
      end
      acpm_pkg::ST_ACC_ADD: begin
        cmd_o.acc_add = 1'b1;
        if (mode_q == acpm_pkg::MODE_FINISH) begin
          state_d = acpm_pkg::ST_DIV;
        end else begin
          state_d = acpm_pkg::ST_IDLE;
        end
      end
      acpm_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = acpm_pkg::ST_SQRT;
          cmd_o.sqrt_start = 1'b1;
        end
      end
      acpm_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_done) state_d = acpm_pkg::ST_RESULT;
      end
      acpm_pkg::ST_RESULT: begin
        if (mode_q == acpm_pkg::MODE_SEED) begin
          cmd_o.seed = 1'b1;
          state_d = acpm_pkg::ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = acpm_pkg::ST_IDLE;
        end
      end
      default: state_d = acpm_pkg::ST_IDLE;
    endcase
    if (state_q == acpm_pkg::ST_ACC_ADD && mode_q == acpm_pkg::MODE_FINISH)
      cmd_o.div_start = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  stall_hold_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");
  accept_idle_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load) |-> state_q == acpm_pkg::ST_IDLE) else $error("load outside idle");
  div_done_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == acpm_pkg::ST_DIV) else $error("stray div done");

endmodule

[rtl/ac_power_rms_meter.sv]
// ac_power_rms_meter: top level, configuration registers, controller and datapath
// depends on acpm_pkg, acpm_ctrl, acpm_datapath
//
// One item at a time. A seed passes through the scale and result states and a sample
// through the scale, filter and accumulate states before the next accept. A finish
// adds a 64-step serial divider run three times, a two-bit-per-cycle square root
// run twice and a result state; the result sits in an output register until
// transferred, and a finish that reaches its result state while that register
// still waits holds there and stalls the input.
module ac_power_rms_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [11:0] raw_u_i,
  input  logic [11:0] raw_i_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] rms_u_o,
  output logic [31:0] rms_i_o,
  output logic [47:0] mean_p_o,
  output logic [23:0] samples_used_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [23:0] gain_u_q, gain_i_q;
  logic [15:0] hp_beta_q;
  logic [31:0] floor_u_q, floor_i_q;
  logic [47:0] floor_p_q;
  acpm_pkg::cmd_t    cmd;
  acpm_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_u_q <= 24'd65536; gain_i_q <= 24'd65536; hp_beta_q <= 16'd655;
      floor_u_q <= 32'd327680; floor_i_q <= 32'd2621; floor_p_q <= 48'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        acpm_pkg::REG_GAIN_U:  gain_u_q  <= cfg_data_i[23:0];
        acpm_pkg::REG_GAIN_I:  gain_i_q  <= cfg_data_i[23:0];
        acpm_pkg::REG_HP_BETA: hp_beta_q <= cfg_data_i[15:0];
        acpm_pkg::REG_FLOOR_U: floor_u_q <= cfg_data_i[31:0];
        acpm_pkg::REG_FLOOR_I: floor_i_q <= cfg_data_i[31:0];
        acpm_pkg::REG_FLOOR_P: floor_p_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  acpm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i,
    .out_valid_o, .out_stall_i, .cmd_o(cmd), .status_i(status)
  );

  acpm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status), .raw_u_i, .raw_i_i,
    .gain_u_i(gain_u_q), .gain_i_i(gain_i_q), .hp_beta_i(hp_beta_q),
    .floor_u_i(floor_u_q), .floor_i_i(floor_i_q), .floor_p_i(floor_p_q),
    .rms_u_o, .rms_i_o, .mean_p_o, .samples_used_o
  );

endmodule
